// ===== hw/rtl/frrc_pkg.sv =====
// Shared types, codes and helpers for the fenced readback ring controller.
`default_nettype none

package frrc_pkg;

    localparam int unsigned MAX_SLOTS  = 8;
    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned NSLOT_W    = 4;
    localparam int unsigned RETRY_W    = 11;
    localparam int unsigned MFF_W      = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned MOD_CNT_W  = $clog2(COUNT_BITS);

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLUSH  = 2'd1;

    localparam logic [1:0] ACT_ACQUIRE = 2'd0;
    localparam logic [1:0] ACT_FINISH  = 2'd1;
    localparam logic [1:0] ACT_LOCK    = 2'd2;
    localparam logic [1:0] ACT_UNLOCK  = 2'd3;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_WRONG     = 3'd4,
        ST_MAP_FAIL  = 3'd5,
        ST_GAVE_UP   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_NEWTARGET = 2'd1,
        MODE_LOCKED    = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOCK_INIT,
        S_SCAN,
        S_ADV,
        S_EVAL,
        S_EMIT,
        S_MODC_START,
        S_MODC_WAIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] dividend;
        logic [NSLOT_W-1:0]    divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } mod_rsp_t;

    // advance a ring position by one, wrapping at the slot count
    function automatic logic [SLOT_W-1:0] slot_step(input logic [SLOT_W-1:0] r,
                                                    input logic [NSLOT_W-1:0] n);
        logic [NSLOT_W-1:0] s;
        s = {1'b0, r} + NSLOT_W'(1);
        slot_step = (s >= n) ? '0 : s[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/frrc_mod_unit.sv =====
// Bit-serial remainder unit: counter value modulo the active slot count.
`default_nettype none

module frrc_mod_unit (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire frrc_pkg::mod_req_t  req,
    output frrc_pkg::mod_rsp_t       rsp
);

    logic [frrc_pkg::COUNT_BITS-1:0] dvd_reg, dvd_next;
    logic [frrc_pkg::NSLOT_W-1:0]    div_reg, div_next;
    logic [frrc_pkg::SLOT_W-1:0]     rem_reg, rem_next;
    logic [frrc_pkg::MOD_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [frrc_pkg::NSLOT_W-1:0]    shifted;
    logic [frrc_pkg::NSLOT_W-1:0]    reduced;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[frrc_pkg::COUNT_BITS-1]};
        reduced   = (shifted >= div_reg) ? shifted - div_reg : shifted;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, drop one divisor if it fits
            rem_next = reduced[frrc_pkg::SLOT_W-1:0];
            dvd_next = {dvd_reg[frrc_pkg::COUNT_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + frrc_pkg::MOD_CNT_W'(1);
            if (cnt_reg == frrc_pkg::MOD_CNT_W'(frrc_pkg::COUNT_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            dvd_reg  <= dvd_next;
            div_reg  <= div_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fenced_readback_ring_controller_unit.sv =====
// Top level of the fenced readback ring controller: sequencer, ring state and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one action word: acquire, finish copy,
//   lock or unlock, together with the per-slot fence and map masks sampled for it.
//   Output channel (out_valid / out_stall) returns exactly one result word per action.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes slot_count
//   (index 0) and max_flush_frames (index 1); it is taken only between actions.
// Sequencing:
//   Acquire, finish copy, unlock and every action refused at decode go straight from
//   decode to the emit step. Lock otherwise adds an init and an evaluate step, plus a scan
//   step and an advance step when skip-ahead scans up to the slot count. One action is
//   in flight at a time; in_stall stays high from acceptance until the result is in the output
//   register, and while a configuration word is offered.
//   Ring positions are kept as residues of the frame counters. Writing a non-zero
//   slot_count recomputes them in a bit-serial remainder unit, in three passes during
//   which neither channel is served.
// Reset: clears the counters, residues, retry count and mode; the ring is disabled
//   (slot_count zero) until configured.
// Back-pressure: the output register holds its word while out_stall is high; the next
//   action may be accepted meanwhile and waits in the emit step until the word drains.
`default_nettype none

module fenced_readback_ring_controller_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    // input channel
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire  [1:0]                         action,
    input  wire                                skip_to_newest,
    input  wire  [7:0]                         fence_done_mask,
    input  wire                                flush_done,
    input  wire  [7:0]                         map_ok_mask,
    // output channel
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [2:0]                         status,
    output logic [2:0]                         slot,
    output logic [31:0]                        frame,
    output logic                               fence_issue,
    output logic                               flush_request,
    // configuration channel
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [frrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [frrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam logic [1:0] PASS_ISSUE = 2'd0;
    localparam logic [1:0] PASS_PREV  = 2'd1;
    localparam logic [1:0] PASS_LOCK  = 2'd2;

    // sequencer and configuration
    frrc_pkg::state_t                 state_reg, state_next;
    frrc_pkg::mode_t                  mode_reg, mode_next;
    logic [frrc_pkg::NSLOT_W-1:0]     slot_count_reg, slot_count_next;
    logic [frrc_pkg::MFF_W-1:0]       mff_reg, mff_next;
    logic [1:0]                       pass_reg, pass_next;

    // ring state: counters and their residues modulo the slot count
    logic [frrc_pkg::COUNT_BITS-1:0]  issue_count_reg, issue_count_next;
    logic [frrc_pkg::COUNT_BITS-1:0]  lock_count_reg, lock_count_next;
    logic [frrc_pkg::SLOT_W-1:0]      issue_mod_reg, issue_mod_next;
    logic [frrc_pkg::SLOT_W-1:0]      prev_mod_reg, prev_mod_next;
    logic [frrc_pkg::SLOT_W-1:0]      lock_mod_reg, lock_mod_next;
    logic [frrc_pkg::RETRY_W-1:0]     retry_reg, retry_next;

    // captured action word
    logic [1:0]                       act_reg, act_next;
    logic                             skip_reg, skip_next;
    logic [7:0]                       fence_reg, fence_next;
    logic                             flushd_reg, flushd_next;
    logic [7:0]                       map_reg, map_next;

    // lock working set
    logic                             passed_reg, passed_next;
    logic [frrc_pkg::COUNT_BITS-1:0]  remain_reg, remain_next;
    logic [frrc_pkg::NSLOT_W-1:0]     run_reg, run_next;
    logic [frrc_pkg::SLOT_W-1:0]      cur_reg, cur_next;
    logic [frrc_pkg::COUNT_BITS-1:0]  cand_reg, cand_next;
    logic [frrc_pkg::SLOT_W-1:0]      cand_mod_reg, cand_mod_next;
    logic                             adv_reg, adv_next;

    // pending result and output register
    frrc_pkg::status_t                res_status_reg, res_status_next;
    logic [frrc_pkg::SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic [frrc_pkg::COUNT_BITS-1:0]  res_frame_reg, res_frame_next;
    logic                             res_fi_reg, res_fi_next;
    logic                             res_fl_reg, res_fl_next;
    logic                             out_valid_reg, out_valid_next;
    frrc_pkg::status_t                out_status_reg, out_status_next;
    logic [frrc_pkg::SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [frrc_pkg::COUNT_BITS-1:0]  out_frame_reg, out_frame_next;
    logic                             out_fi_reg, out_fi_next;
    logic                             out_fl_reg, out_fl_next;

    // combinational helpers
    logic [frrc_pkg::NSLOT_W-1:0]     n_active;
    logic [frrc_pkg::NSLOT_W-1:0]     cfg_n;
    frrc_pkg::mode_t                  need_mode;
    logic [frrc_pkg::SLOT_W-1:0]      issue_mod_inc;
    logic [frrc_pkg::SLOT_W-1:0]      lock_mod_inc;
    logic [frrc_pkg::SLOT_W-1:0]      probe;
    logic [frrc_pkg::RETRY_W:0]       tries;
    logic [frrc_pkg::RETRY_W:0]       give_up;
    logic                             flush;
    logic                             pass_eff;
    frrc_pkg::mod_req_t               mod_req;
    frrc_pkg::mod_rsp_t               mod_rsp;

    frrc_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // slot counts above the ring size act as the ring size
    assign n_active = (slot_count_reg > frrc_pkg::NSLOT_W'(frrc_pkg::MAX_SLOTS))
                    ? frrc_pkg::NSLOT_W'(frrc_pkg::MAX_SLOTS) : slot_count_reg;
    assign cfg_n    = (cfg_data[frrc_pkg::NSLOT_W-1:0] > frrc_pkg::NSLOT_W'(frrc_pkg::MAX_SLOTS))
                    ? frrc_pkg::NSLOT_W'(frrc_pkg::MAX_SLOTS) : cfg_data[frrc_pkg::NSLOT_W-1:0];

    assign in_stall  = (state_reg != frrc_pkg::S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == frrc_pkg::S_IDLE);

    always_comb
    begin
        // defaults: hold everything
        state_next       = state_reg;
        mode_next        = mode_reg;
        slot_count_next  = slot_count_reg;
        mff_next         = mff_reg;
        pass_next        = pass_reg;
        issue_count_next = issue_count_reg;
        lock_count_next  = lock_count_reg;
        issue_mod_next   = issue_mod_reg;
        prev_mod_next    = prev_mod_reg;
        lock_mod_next    = lock_mod_reg;
        retry_next       = retry_reg;
        act_next         = act_reg;
        skip_next        = skip_reg;
        fence_next       = fence_reg;
        flushd_next      = flushd_reg;
        map_next         = map_reg;
        passed_next      = passed_reg;
        remain_next      = remain_reg;
        run_next         = run_reg;
        cur_next         = cur_reg;
        cand_next        = cand_reg;
        cand_mod_next    = cand_mod_reg;
        adv_next         = adv_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_frame_next   = res_frame_reg;
        res_fi_next      = res_fi_reg;
        res_fl_next      = res_fl_reg;
        out_status_next  = out_status_reg;
        out_slot_next    = out_slot_reg;
        out_frame_next   = out_frame_reg;
        out_fi_next      = out_fi_reg;
        out_fl_next      = out_fl_reg;
        // drop the output word once it is taken
        out_valid_next   = out_valid_reg && out_stall;

        mod_req.start    = 1'b0;
        mod_req.divisor  = n_active;
        mod_req.dividend = issue_count_reg;

        need_mode = (act_reg == frrc_pkg::ACT_FINISH) ? frrc_pkg::MODE_NEWTARGET
                  : (act_reg == frrc_pkg::ACT_UNLOCK) ? frrc_pkg::MODE_LOCKED
                  : frrc_pkg::MODE_NORMAL;
        issue_mod_inc = (issue_count_reg == '1) ? '0
                      : frrc_pkg::slot_step(issue_mod_reg, n_active);
        lock_mod_inc  = frrc_pkg::slot_step(lock_mod_reg, n_active);
        probe         = frrc_pkg::slot_step(cur_reg, n_active);

        tries    = {1'b0, retry_reg} + (frrc_pkg::RETRY_W + 1)'(1);
        give_up  = {1'b0, mff_reg, 1'b0} + (frrc_pkg::RETRY_W + 1)'(1);
        flush    = !passed_reg && (tries > {2'b00, mff_reg});
        pass_eff = passed_reg || (flush && flushd_reg);

        unique case (state_reg)
            frrc_pkg::S_IDLE:
            begin
                if (cfg_valid)
                begin
                    unique case (cfg_index)
                        frrc_pkg::CFG_SLOT_COUNT:
                        begin
                            slot_count_next = cfg_data[frrc_pkg::NSLOT_W-1:0];
                            // residues must follow the new ring size
                            if (cfg_n != '0)
                            begin
                                pass_next  = PASS_ISSUE;
                                state_next = frrc_pkg::S_MODC_START;
                            end
                        end
                        frrc_pkg::CFG_MAX_FLUSH:
                        begin
                            mff_next = cfg_data[frrc_pkg::MFF_W-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (in_valid)
                begin
                    act_next    = action;
                    skip_next   = skip_to_newest;
                    fence_next  = fence_done_mask;
                    flushd_next = flush_done;
                    map_next    = map_ok_mask;
                    state_next  = frrc_pkg::S_DECODE;
                end
            end

            frrc_pkg::S_DECODE:
            begin
                res_slot_next  = '0;
                res_frame_next = '0;
                res_fi_next    = 1'b0;
                res_fl_next    = 1'b0;
                state_next     = frrc_pkg::S_EMIT;
                if (mode_reg != need_mode)
                begin
                    res_status_next = frrc_pkg::ST_WRONG;
                end
                else if (n_active == '0)
                begin
                    res_status_next = frrc_pkg::ST_EMPTY;
                end
                else
                begin
                    unique case (act_reg)
                        frrc_pkg::ACT_ACQUIRE:
                        begin
                            res_slot_next = issue_mod_reg;
                            if (issue_mod_inc == lock_mod_reg &&
                                lock_count_reg < issue_count_reg)
                            begin
                                res_status_next = frrc_pkg::ST_FULL;
                            end
                            else if (!fence_reg[issue_mod_reg])
                            begin
                                res_status_next = frrc_pkg::ST_NOT_READY;
                            end
                            else
                            begin
                                res_status_next  = frrc_pkg::ST_GRANTED;
                                res_frame_next   = issue_count_reg;
                                mode_next        = frrc_pkg::MODE_NEWTARGET;
                                issue_count_next = issue_count_reg + 1'b1;
                                prev_mod_next    = issue_mod_reg;
                                issue_mod_next   = issue_mod_inc;
                            end
                        end
                        frrc_pkg::ACT_FINISH:
                        begin
                            res_status_next = frrc_pkg::ST_GRANTED;
                            res_slot_next   = prev_mod_reg;
                            res_frame_next  = issue_count_reg - 1'b1;
                            res_fi_next     = 1'b1;
                            mode_next       = frrc_pkg::MODE_NORMAL;
                        end
                        frrc_pkg::ACT_LOCK:
                        begin
                            if (lock_count_reg >= issue_count_reg)
                            begin
                                res_status_next = frrc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = frrc_pkg::S_LOCK_INIT;
                            end
                        end
                        frrc_pkg::ACT_UNLOCK:
                        begin
                            res_status_next = frrc_pkg::ST_GRANTED;
                            res_slot_next   = lock_mod_reg;
                            res_frame_next  = lock_count_reg;
                            lock_count_next = lock_count_reg + 1'b1;
                            lock_mod_next   = lock_mod_inc;
                            mode_next       = frrc_pkg::MODE_NORMAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            frrc_pkg::S_LOCK_INIT:
            begin
                passed_next   = fence_reg[lock_mod_reg];
                remain_next   = issue_count_reg - 1'b1 - lock_count_reg;
                cur_next      = lock_mod_reg;
                run_next      = '0;
                cand_next     = lock_count_reg;
                cand_mod_next = lock_mod_reg;
                adv_next      = 1'b0;
                if (skip_reg && fence_reg[lock_mod_reg])
                begin
                    state_next = frrc_pkg::S_SCAN;
                end
                else
                begin
                    state_next = frrc_pkg::S_EVAL;
                end
            end

            frrc_pkg::S_SCAN:
            begin
                // walk one slot a cycle while the next issued slot has completed
                if (run_reg < n_active &&
                    {{(frrc_pkg::COUNT_BITS-frrc_pkg::NSLOT_W){1'b0}}, run_reg} < remain_reg &&
                    fence_reg[probe])
                begin
                    run_next = run_reg + 1'b1;
                    cur_next = probe;
                end
                else
                begin
                    state_next = frrc_pkg::S_ADV;
                end
            end

            frrc_pkg::S_ADV:
            begin
                // a full lap of completed slots jumps straight to the newest
                if (run_reg == n_active)
                begin
                    cand_next     = issue_count_reg - 1'b1;
                    cand_mod_next = prev_mod_reg;
                end
                else
                begin
                    cand_next     = lock_count_reg +
                                    {{(frrc_pkg::COUNT_BITS-frrc_pkg::NSLOT_W){1'b0}}, run_reg};
                    cand_mod_next = cur_reg;
                end
                adv_next   = (run_reg != '0);
                state_next = frrc_pkg::S_EVAL;
            end

            frrc_pkg::S_EVAL:
            begin
                res_fi_next    = 1'b0;
                res_fl_next    = flush;
                res_frame_next = '0;
                res_slot_next  = cand_mod_reg;
                retry_next     = passed_reg ? retry_reg : tries[frrc_pkg::RETRY_W-1:0];
                state_next     = frrc_pkg::S_EMIT;
                if (pass_eff)
                begin
                    if (map_reg[cand_mod_reg])
                    begin
                        res_status_next = frrc_pkg::ST_GRANTED;
                        res_frame_next  = cand_reg;
                        lock_count_next = cand_reg;
                        lock_mod_next   = cand_mod_reg;
                        retry_next      = '0;
                        mode_next       = frrc_pkg::MODE_LOCKED;
                    end
                    else if (!adv_reg)
                    begin
                        res_status_next = frrc_pkg::ST_MAP_FAIL;
                    end
                    else if (map_reg[lock_mod_reg])
                    begin
                        // fall back to the oldest slot
                        res_status_next = frrc_pkg::ST_GRANTED;
                        res_slot_next   = lock_mod_reg;
                        res_frame_next  = lock_count_reg;
                        retry_next      = '0;
                        mode_next       = frrc_pkg::MODE_LOCKED;
                    end
                    else
                    begin
                        // fallback failed too: drop the oldest slot
                        res_status_next = frrc_pkg::ST_MAP_FAIL;
                        res_slot_next   = lock_mod_reg;
                        retry_next      = '0;
                        lock_count_next = lock_count_reg + 1'b1;
                        lock_mod_next   = lock_mod_inc;
                    end
                end
                else if (tries > give_up)
                begin
                    res_status_next = frrc_pkg::ST_GAVE_UP;
                    retry_next      = '0;
                    lock_count_next = lock_count_reg + 1'b1;
                    lock_mod_next   = lock_mod_inc;
                end
                else
                begin
                    res_status_next = frrc_pkg::ST_NOT_READY;
                end
            end

            frrc_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_frame_next  = res_frame_reg;
                    out_fi_next     = res_fi_reg;
                    out_fl_next     = res_fl_reg;
                    state_next      = frrc_pkg::S_IDLE;
                end
            end

            frrc_pkg::S_MODC_START:
            begin
                mod_req.start = 1'b1;
                case (pass_reg)
                    PASS_PREV: mod_req.dividend = issue_count_reg - 1'b1;
                    PASS_LOCK: mod_req.dividend = lock_count_reg;
                    default:   mod_req.dividend = issue_count_reg;
                endcase
                state_next = frrc_pkg::S_MODC_WAIT;
            end

            frrc_pkg::S_MODC_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    case (pass_reg)
                        PASS_PREV: prev_mod_next  = mod_rsp.rem;
                        PASS_LOCK: lock_mod_next  = mod_rsp.rem;
                        default:   issue_mod_next = mod_rsp.rem;
                    endcase
                    if (pass_reg == PASS_LOCK)
                    begin
                        state_next = frrc_pkg::S_IDLE;
                    end
                    else
                    begin
                        pass_next  = pass_reg + 1'b1;
                        state_next = frrc_pkg::S_MODC_START;
                    end
                end
            end

            default:
            begin
                state_next = frrc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= frrc_pkg::S_IDLE;
            mode_reg       <= frrc_pkg::MODE_NORMAL;
            slot_count_reg <= '0;
            mff_reg        <= '0;
            pass_reg       <= PASS_ISSUE;
            issue_count_reg <= '0;
            lock_count_reg <= '0;
            issue_mod_reg  <= '0;
            prev_mod_reg   <= '0;
            lock_mod_reg   <= '0;
            retry_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            slot_count_reg <= slot_count_next;
            mff_reg        <= mff_next;
            pass_reg       <= pass_next;
            issue_count_reg <= issue_count_next;
            lock_count_reg <= lock_count_next;
            issue_mod_reg  <= issue_mod_next;
            prev_mod_reg   <= prev_mod_next;
            lock_mod_reg   <= lock_mod_next;
            retry_reg      <= retry_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        skip_reg       <= skip_next;
        fence_reg      <= fence_next;
        flushd_reg     <= flushd_next;
        map_reg        <= map_next;
        passed_reg     <= passed_next;
        remain_reg     <= remain_next;
        run_reg        <= run_next;
        cur_reg        <= cur_next;
        cand_reg       <= cand_next;
        cand_mod_reg   <= cand_mod_next;
        adv_reg        <= adv_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_frame_reg  <= res_frame_next;
        res_fi_reg     <= res_fi_next;
        res_fl_reg     <= res_fl_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_frame_reg  <= out_frame_next;
        out_fi_reg     <= out_fi_next;
        out_fl_reg     <= out_fl_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign slot          = out_slot_reg;
    assign frame         = out_frame_reg;
    assign fence_issue   = out_fi_reg;
    assign flush_request = out_fl_reg;

    a_lock_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frrc_pkg::S_DECODE && n_active != '0) |->
        ({1'b0, lock_mod_reg} < n_active))
        else $error("lock residue outside the ring");

    a_issue_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frrc_pkg::S_DECODE && n_active != '0) |->
        ({1'b0, issue_mod_reg} < n_active && {1'b0, prev_mod_reg} < n_active))
        else $error("issue residue outside the ring");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == frrc_pkg::S_SCAN) |-> (run_reg <= n_active))
        else $error("skip-ahead scan ran past the slot count");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == frrc_pkg::S_EMIT))
        else $error("result word raised outside the emit step");

endmodule

`default_nettype wire

// ===== verif/tb_fenced_readback_ring_controller_unit.sv =====
// Self-checking testbench for the fenced readback ring controller: stimulus, prediction, checks.
`timescale 1ns / 1ps

module tb_fenced_readback_ring_controller_unit;

    // Run length guard: far above the slowest legal run (lock scans, stalls, hold-offs,
    // residue recomputation after every slot_count write).
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 9;

    // one action word as offered on the input channel
    typedef struct packed {
        logic [1:0] action;
        logic       skip_to_newest;
        logic [7:0] fence_done_mask;
        logic       flush_done;
        logic [7:0] map_ok_mask;
    } ring_word_t;

    // one result word as returned on the output channel
    typedef struct packed {
        frrc_pkg::status_t status;
        logic [2:0]        slot;
        logic [31:0]       frame;
        logic              fence_issue;
        logic              flush_request;
    } ring_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                            in_valid        = 1'b0;
    logic                            in_stall;
    logic [1:0]                      action          = '0;
    logic                            skip_to_newest  = 1'b0;
    logic [7:0]                      fence_done_mask = '0;
    logic                            flush_done      = 1'b0;
    logic [7:0]                      map_ok_mask     = '0;
    logic                            out_valid;
    logic                            out_stall       = 1'b0;
    logic [2:0]                      status;
    logic [2:0]                      slot;
    logic [31:0]                     frame;
    logic                            fence_issue;
    logic                            flush_request;
    logic                            cfg_valid       = 1'b0;
    logic                            cfg_ready;
    logic [frrc_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [frrc_pkg::CFG_DATA_W-1:0] cfg_data        = '0;

    // Shadow of the ring: registers, mode, frame counters and retry count, advanced
    // once per accepted word.
    logic [3:0]        cfg_slots       = '0;
    logic [9:0]        cfg_flush_limit = '0;
    frrc_pkg::mode_t   ring_mode       = frrc_pkg::MODE_NORMAL;
    logic [31:0]       frames_issued   = '0;
    logic [31:0]       frames_locked   = '0;
    logic [10:0]       lock_retries    = '0;

    ring_word_t   pending_words[$];
    ring_result_t expected_results[$];
    ring_word_t   offered_word;
    ring_result_t oldest_result;

    int unsigned  words_accepted  = 0;
    int unsigned  results_checked = 0;
    int unsigned  mismatches      = 0;
    int unsigned  cycle_cnt       = 0;
    int unsigned  settings_used   = 0;
    int unsigned  status_seen [0:7];
    int unsigned  flushes_seen    = 0;
    int unsigned  hold_left       = 0;
    int unsigned  next_hold_at    = 300;

    // register settings and random word counts of the random phases
    int unsigned  phase_slots [0:PHASES-1] = '{8, 1, 15, 0, 3, 5, 2, 8, 4};
    int unsigned  phase_limit [0:PHASES-1] = '{0, 1, 1023, 2, 3, 0, 1, 7, 0};
    int unsigned  phase_words [0:PHASES-1] = '{260, 200, 200, 40, 200, 220, 200, 230, 200};

    // both sides run without idling for a while in the middle of the run
    wire quiet_stretch = (words_accepted >= 700) && (words_accepted < 900);

    fenced_readback_ring_controller_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .skip_to_newest  (skip_to_newest),
        .fence_done_mask (fence_done_mask),
        .flush_done      (flush_done),
        .map_ok_mask     (map_ok_mask),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .slot            (slot),
        .frame           (frame),
        .fence_issue     (fence_issue),
        .flush_request   (flush_request),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // slots in use: values above the ring size act as the ring size
    function automatic logic [31:0] ring_depth();
        return (cfg_slots > frrc_pkg::MAX_SLOTS) ? 32'(frrc_pkg::MAX_SLOTS)
                                                 : {28'd0, cfg_slots};
    endfunction

    // Work out the result of one accepted word and advance the shadow ring.
    function automatic ring_result_t ring_predict(input ring_word_t w);
        ring_result_t    r;
        frrc_pkg::mode_t need;
        logic [31:0]     n;
        logic [31:0]     idx;
        logic [31:0]     fr;
        logic [31:0]     regular;
        logic [31:0]     remain;
        logic [31:0]     run;
        logic [31:0]     j;
        logic [31:0]     tries;
        logic [31:0]     give_up;
        logic            passed;
        logic            halt;
        r    = '0;
        n    = ring_depth();
        need = (w.action == frrc_pkg::ACT_FINISH) ? frrc_pkg::MODE_NEWTARGET :
               (w.action == frrc_pkg::ACT_UNLOCK) ? frrc_pkg::MODE_LOCKED :
               frrc_pkg::MODE_NORMAL;
        // mode guard comes before the disabled check
        if (ring_mode != need)
        begin
            r.status = frrc_pkg::ST_WRONG;
            return r;
        end
        if (n == 0)
        begin
            r.status = frrc_pkg::ST_EMPTY;
            return r;
        end
        case (w.action)
            frrc_pkg::ACT_ACQUIRE:
            begin
                idx    = frames_issued % n;
                r.slot = idx[2:0];
                if ((frames_issued + 32'd1) % n == frames_locked % n &&
                    frames_locked < frames_issued)
                    r.status = frrc_pkg::ST_FULL;
                else if (!w.fence_done_mask[idx[2:0]])
                    r.status = frrc_pkg::ST_NOT_READY;
                else
                begin
                    r.status      = frrc_pkg::ST_GRANTED;
                    r.frame       = frames_issued;
                    ring_mode     = frrc_pkg::MODE_NEWTARGET;
                    frames_issued = frames_issued + 32'd1;
                end
            end
            frrc_pkg::ACT_FINISH:
            begin
                fr            = frames_issued - 32'd1;
                idx           = fr % n;
                r.status      = frrc_pkg::ST_GRANTED;
                r.slot        = idx[2:0];
                r.frame       = fr;
                r.fence_issue = 1'b1;
                ring_mode     = frrc_pkg::MODE_NORMAL;
            end
            frrc_pkg::ACT_UNLOCK:
            begin
                idx           = frames_locked % n;
                r.status      = frrc_pkg::ST_GRANTED;
                r.slot        = idx[2:0];
                r.frame       = frames_locked;
                frames_locked = frames_locked + 32'd1;
                ring_mode     = frrc_pkg::MODE_NORMAL;
            end
            default:
            begin
                if (frames_locked >= frames_issued)
                begin
                    r.status = frrc_pkg::ST_EMPTY;
                    return r;
                end
                give_up = 32'd2 * {22'd0, cfg_flush_limit} + 32'd1;
                regular = frames_locked;
                idx     = frames_locked % n;
                passed  = w.fence_done_mask[idx[2:0]];
                // skip ahead over consecutive completed slots, never past the newest issued
                if (w.skip_to_newest && passed)
                begin
                    remain = frames_issued - 32'd1 - frames_locked;
                    run    = '0;
                    halt   = 1'b0;
                    for (j = 32'd1; j <= n && run < remain && !halt; j = j + 32'd1)
                    begin
                        idx = (frames_locked + j) % n;
                        if (w.fence_done_mask[idx[2:0]])
                            run = run + 32'd1;
                        else
                            halt = 1'b1;
                    end
                    if (run == n)
                        run = remain;
                    frames_locked = frames_locked + run;
                end
                idx    = frames_locked % n;
                r.slot = idx[2:0];
                tries  = {21'd0, lock_retries};
                if (!passed)
                begin
                    tries        = {21'd0, lock_retries} + 32'd1;
                    lock_retries = tries[10:0];
                    if (tries > {22'd0, cfg_flush_limit})
                    begin
                        r.flush_request = 1'b1;
                        passed          = w.flush_done;
                    end
                end
                if (passed)
                begin
                    if (!w.map_ok_mask[idx[2:0]])
                    begin
                        // no skip taken: fail and keep the retry count
                        if (regular >= frames_locked)
                        begin
                            r.status = frrc_pkg::ST_MAP_FAIL;
                            return r;
                        end
                        // fall back to the oldest slot; drop it if that fails too
                        frames_locked = regular;
                        idx           = frames_locked % n;
                        r.slot        = idx[2:0];
                        if (!w.map_ok_mask[idx[2:0]])
                        begin
                            lock_retries = '0;
                            if (frames_locked < frames_issued)
                                frames_locked = frames_locked + 32'd1;
                            r.status = frrc_pkg::ST_MAP_FAIL;
                            return r;
                        end
                    end
                    lock_retries = '0;
                    ring_mode    = frrc_pkg::MODE_LOCKED;
                    r.status     = frrc_pkg::ST_GRANTED;
                    r.frame      = frames_locked;
                    return r;
                end
                if (tries > give_up)
                begin
                    lock_retries = '0;
                    if (frames_locked < frames_issued)
                        frames_locked = frames_locked + 32'd1;
                    r.status = frrc_pkg::ST_GAVE_UP;
                    return r;
                end
                r.status = frrc_pkg::ST_NOT_READY;
            end
        endcase
        return r;
    endfunction

    function automatic ring_word_t mk_word(input logic [1:0] act, input logic skip,
                                           input logic [7:0] fence, input logic flushed,
                                           input logic [7:0] map_ok);
        ring_word_t w;
        w.action          = act;
        w.skip_to_newest  = skip;
        w.fence_done_mask = fence;
        w.flush_done      = flushed;
        w.map_ok_mask     = map_ok;
        return w;
    endfunction

    // Mostly well-formed producer/consumer traffic that follows the ring's mode, with
    // some noise words of any action.
    function automatic ring_word_t next_word();
        ring_word_t  w;
        logic [31:0] n;
        logic [31:0] backlog;
        n       = ring_depth();
        backlog = frames_issued - frames_locked;
        w.skip_to_newest  = 1'($urandom_range(1));
        w.flush_done      = 1'($urandom_range(1));
        w.fence_done_mask = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom | $urandom);
        w.map_ok_mask     = ($urandom_range(9) < 7) ? 8'hFF : 8'($urandom | $urandom);
        if ($urandom_range(99) < 12)
            w.action = 2'($urandom_range(3));
        else if (ring_mode == frrc_pkg::MODE_NEWTARGET)
            w.action = frrc_pkg::ACT_FINISH;
        else if (ring_mode == frrc_pkg::MODE_LOCKED)
            w.action = frrc_pkg::ACT_UNLOCK;
        else if (backlog == 0)
            w.action = ($urandom_range(9) < 8) ? frrc_pkg::ACT_ACQUIRE : frrc_pkg::ACT_LOCK;
        else if (n != 0 && backlog >= n - 32'd1)
            w.action = ($urandom_range(9) < 7) ? frrc_pkg::ACT_LOCK : frrc_pkg::ACT_ACQUIRE;
        else
            w.action = $urandom_range(1) ? frrc_pkg::ACT_LOCK : frrc_pkg::ACT_ACQUIRE;
        return w;
    endfunction

    // Hand one word to the driver once the previous one has been taken, so that a
    // random word is chosen from the ring's mode after every earlier word.
    task automatic queue_word(input ring_word_t w, input bit pick_random);
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid);
        if (pick_random)
            w = next_word();
        pending_words.push_back(w);
    endtask

    // wait until every word is taken and answered, then let the block settle
    task automatic drain_ring();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input logic [frrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [frrc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == frrc_pkg::CFG_SLOT_COUNT)
            cfg_slots = val[3:0];
        else if (idx == frrc_pkg::CFG_MAX_FLUSH)
            cfg_flush_limit = val[9:0];
    endtask

    task automatic set_ring(input int unsigned slots, input int unsigned flush_limit);
        drain_ring();
        write_reg(frrc_pkg::CFG_SLOT_COUNT, frrc_pkg::CFG_DATA_W'(slots));
        write_reg(frrc_pkg::CFG_MAX_FLUSH, frrc_pkg::CFG_DATA_W'(flush_limit));
        settings_used++;
    endtask

    // Driver: present the next pending word, hold it until taken, idle now and then.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(ring_predict(offered_word));
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && (quiet_stretch || $urandom_range(99) >= 18))
                begin
                    offered_word     = pending_words.pop_front();
                    in_valid        <= 1'b1;
                    action          <= offered_word.action;
                    skip_to_newest  <= offered_word.skip_to_newest;
                    fence_done_mask <= offered_word.fence_done_mask;
                    flush_done      <= offered_word.flush_done;
                    map_ok_mask     <= offered_word.map_ok_mask;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: armed every so often and counted down cycle by cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            next_hold_at <= 300;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (results_checked >= next_hold_at)
        begin
            hold_left    <= 240;
            next_hold_at <= next_hold_at + 900;
        end
    end

    // Monitor: compare each result word with the oldest expectation; stall at random,
    // and hold off throughout a long stretch so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d slot %0d frame %0d",
                           status, slot, frame);
                    mismatches++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest_result.status, status);
                        mismatches++;
                    end
                    if (slot !== oldest_result.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", oldest_result.slot, slot);
                        mismatches++;
                    end
                    if (frame !== oldest_result.frame)
                    begin
                        $error("frame: expected %0d, actual %0d", oldest_result.frame, frame);
                        mismatches++;
                    end
                    if (fence_issue !== oldest_result.fence_issue)
                    begin
                        $error("fence_issue: expected %0d, actual %0d",
                               oldest_result.fence_issue, fence_issue);
                        mismatches++;
                    end
                    if (flush_request !== oldest_result.flush_request)
                    begin
                        $error("flush_request: expected %0d, actual %0d",
                               oldest_result.flush_request, flush_request);
                        mismatches++;
                    end
                    status_seen[oldest_result.status]++;
                    if (oldest_result.flush_request)
                        flushes_seen++;
                end
                results_checked++;
            end
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
            end
            else if (quiet_stretch)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 18);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("[fenced_readback_ring_controller_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < 8; k++)
            status_seen[k] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // disabled ring straight out of reset: refusals and mode guard
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b1, 8'hFF, 1'b1, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'h00, 1'b0, 8'h00), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_UNLOCK, 1'b0, 8'h00, 1'b0, 8'h00), 1'b0);

        // four slots, forced flush on the first failed try
        set_ring(4, 0);
        // nothing to lock, then fence pending
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'h00, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        // wrong state
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        // ring full
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        // flush not ready, then flush passes
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'h00, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'h00, 1'b1, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_UNLOCK, 1'b0, 8'h00, 1'b0, 8'h00), 1'b0);
        // give up on the second try
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'h00, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'h00, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        // skip ahead, fall back to the oldest slot
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b1, 8'hFF, 1'b0, 8'h04), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_UNLOCK, 1'b1, 8'hFF, 1'b1, 8'hFF), 1'b0);
        // map fail with the retry count kept
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b0, 8'hFF, 1'b0, 8'h00), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_ACQUIRE, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        queue_word(mk_word(frrc_pkg::ACT_FINISH, 1'b0, 8'hFF, 1'b0, 8'hFF), 1'b0);
        // fallback fails too
        queue_word(mk_word(frrc_pkg::ACT_LOCK, 1'b1, 8'hFF, 1'b0, 8'h00), 1'b0);

        // random phases across ring sizes and flush limits, extremes included
        for (int p = 0; p < PHASES; p++)
        begin
            set_ring(phase_slots[p], phase_limit[p]);
            for (int k = 0; k < phase_words[p]; k++)
                queue_word('0, 1'b1);
        end

        drain_ring();
        repeat (40) @(posedge clk);
        $display("Checked %0d result words for %0d action words over %0d ring settings.",
                 results_checked, words_accepted, settings_used);
        $display("Grants %0d, refusals %0d, gave up %0d, map failures %0d, forced flushes %0d.",
                 status_seen[frrc_pkg::ST_GRANTED],
                 status_seen[frrc_pkg::ST_EMPTY] + status_seen[frrc_pkg::ST_FULL] +
                 status_seen[frrc_pkg::ST_NOT_READY] + status_seen[frrc_pkg::ST_WRONG],
                 status_seen[frrc_pkg::ST_GAVE_UP], status_seen[frrc_pkg::ST_MAP_FAIL],
                 flushes_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[fenced_readback_ring_controller_unit] OK");
        else
            $display("[fenced_readback_ring_controller_unit] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/frrc_pkg.sv
hw/rtl/frrc_mod_unit.sv
hw/rtl/fenced_readback_ring_controller_unit.sv
verif/tb_fenced_readback_ring_controller_unit.sv
